@@ rtl/fqd_pkg.sv @@
`default_nettype none

package fqd_pkg;

	// Fixed field widths of the request and result channels
	localparam int REQ_W    = 2;
	localparam int HANDLE_W = 32;
	localparam int STATUS_W = 2;
	localparam int LEN_W    = 5;

	// Default configuration of the queue
	localparam int DEPTH_DEF       = 16;
	localparam int HANDLE_BITS_DEF = 32;

	typedef logic [REQ_W-1:0]    req_code_t;
	typedef logic [HANDLE_W-1:0] handle_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [LEN_W-1:0]    len_t;

	// Request codes
	localparam req_code_t REQ_ENQ = 2'd0;
	localparam req_code_t REQ_DEQ = 2'd1;
	localparam req_code_t REQ_DEL = 2'd2;

	// Result status codes
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_ZERO      = 2'd1;
	localparam status_t ST_FULLEMPTY = 2'd2;
	localparam status_t ST_NOTFOUND  = 2'd3;

endpackage

`default_nettype wire

@@ rtl/fqd_if.sv @@
`default_nettype none

// Request channel
interface fqd_req_if;
	import fqd_pkg::*;

	logic      valid;
	logic      ready;
	req_code_t req_type;
	handle_t   handle_in;

	modport source (output valid, output req_type, output handle_in, input ready);
	modport sink   (input valid, input req_type, input handle_in, output ready);
endinterface

// Result channel
interface fqd_rsp_if;
	import fqd_pkg::*;

	logic    valid;
	logic    ready;
	status_t status;
	handle_t handle_out;
	len_t    length;

	modport source (output valid, output status, output handle_out, output length,
		input ready);
	modport sink   (input valid, input status, input handle_out, input length,
		output ready);
endinterface

`default_nettype wire

@@ rtl/fqd_ram.sv @@
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle
module fqd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/fifo_queue_with_delete.sv @@
// Enqueue and invalid or unused requests: result in the cycle after the transfer.
// Dequeue: result follows one registered read of the store, in state S_DEQ.
// Delete: scans the store one entry per cycle, then closes the gap one entry per
// cycle, then registers the result.
// One request at a time; the next is taken once the result register is free.
// Reset (arst_n low, asynchronous) empties the queue; the store itself is not cleared.
`default_nettype none

module fifo_queue_with_delete #(
	parameter int DEPTH       = fqd_pkg::DEPTH_DEF,
	parameter int HANDLE_BITS = fqd_pkg::HANDLE_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	fqd_req_if.sink    req,
	fqd_rsp_if.source  rsp
);
	import fqd_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int OW = $clog2(DEPTH + 2);
	localparam int SW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_DEQ   = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_SHIFT = 2'd3;

	// Physical slot of a queue offset, off never above DEPTH
	function automatic logic [AW-1:0] slot_of(logic [AW-1:0] base, logic [OW-1:0] off);
		logic [OW:0] sum;
		sum = (OW+1)'(base) + (OW+1)'(off);
		if (sum >= (OW+1)'(DEPTH)) begin
			sum = sum - (OW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	logic [1:0]    state_q, state_d;
	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] count_q, count_d;
	logic [OW-1:0] off_q, off_d;
	logic [SW-1:0] key_q, key_d;

	logic          out_valid_q, out_valid_d;
	status_t       status_q, status_d;
	handle_t       hout_q, hout_d;
	len_t          len_q;

	logic          res_fire;
	logic          req_xfer;
	logic [SW-1:0] h_in;
	logic [OW-1:0] cnt_off;
	logic [OW-1:0] off_p1;
	logic [OW-1:0] off_p2;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [SW-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [SW-1:0] ram_rdata;

	fqd_ram #(
		.WIDTH (SW),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign h_in     = SW'(req.handle_in);
	assign req.ready = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);
	assign req_xfer = req.valid && req.ready;
	assign cnt_off  = OW'(count_q);
	assign off_p1   = off_q + OW'(1);
	assign off_p2   = off_q + OW'(2);

	// Request sequencing and store access
	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		count_d     = count_q;
		off_d       = off_q;
		key_d       = key_q;
		out_valid_d = out_valid_q && !rsp.ready;
		status_d    = status_q;
		hout_d      = hout_q;
		res_fire    = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = slot_of(head_q, cnt_off);
		ram_wdata   = h_in;
		ram_raddr   = head_q;

		unique case (state_q)
			S_IDLE: begin
				if (req_xfer) begin
					hout_d = '0;
					if (req.req_type == REQ_ENQ) begin
						res_fire = 1'b1;
						if (h_in == '0) begin
							status_d = ST_ZERO;
						end else if (count_q == CW'(DEPTH)) begin
							status_d = ST_FULLEMPTY;
						end else begin
							status_d = ST_OK;
							ram_we   = 1'b1;
							count_d  = count_q + CW'(1);
						end
					end else if (req.req_type == REQ_DEQ) begin
						if (count_q == '0) begin
							res_fire = 1'b1;
							status_d = ST_FULLEMPTY;
						end else begin
							state_d = S_DEQ;
						end
					end else if (req.req_type == REQ_DEL) begin
						if (h_in == '0) begin
							res_fire = 1'b1;
							status_d = ST_ZERO;
						end else if (count_q == '0) begin
							res_fire = 1'b1;
							status_d = ST_FULLEMPTY;
						end else begin
							key_d   = h_in;
							off_d   = '0;
							state_d = S_SCAN;
						end
					end else begin
						// unused code: no change
						res_fire = 1'b1;
						status_d = ST_OK;
					end
				end
			end
			S_DEQ: begin
				res_fire = 1'b1;
				status_d = ST_OK;
				hout_d   = HANDLE_W'(ram_rdata);
				head_d   = slot_of(head_q, OW'(1));
				count_d  = count_q - CW'(1);
				state_d  = S_IDLE;
			end
			S_SCAN: begin
				// read data holds the entry at offset off_q; fetch the next one
				ram_raddr = slot_of(head_q, off_p1);
				if (ram_rdata == key_q) begin
					if (off_p1 < cnt_off) begin
						state_d = S_SHIFT;
					end else begin
						res_fire = 1'b1;
						status_d = ST_OK;
						count_d  = count_q - CW'(1);
						state_d  = S_IDLE;
					end
				end else if (off_p1 < cnt_off) begin
					off_d = off_p1;
				end else begin
					res_fire = 1'b1;
					status_d = ST_NOTFOUND;
					state_d  = S_IDLE;
				end
			end
			S_SHIFT: begin
				// read data holds offset off_q+1; move it down one place
				ram_we    = 1'b1;
				ram_waddr = slot_of(head_q, off_q);
				ram_wdata = ram_rdata;
				if (off_p2 < cnt_off) begin
					ram_raddr = slot_of(head_q, off_p2);
					off_d     = off_p1;
				end else begin
					res_fire = 1'b1;
					status_d = ST_OK;
					count_d  = count_q - CW'(1);
					state_d  = S_IDLE;
				end
			end
		endcase

		if (res_fire) begin
			out_valid_d = 1'b1;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Work registers and result payload
	always_ff @(posedge clk) begin
		off_q    <= off_d;
		key_q    <= key_d;
		status_q <= status_d;
		hout_q   <= hout_d;
		if (res_fire) begin
			len_q <= LEN_W'(count_d);
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.handle_out = hout_q;
	assign rsp.length     = len_q;

endmodule

`default_nettype wire

@@ rtl/fqd_checker.sv @@
`default_nettype none

module fqd_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             req_valid,
	input wire logic             req_ready,
	input wire logic             rsp_valid,
	input wire logic             rsp_ready,
	input wire fqd_pkg::status_t rsp_status,
	input wire fqd_pkg::handle_t rsp_handle,
	input wire fqd_pkg::len_t    rsp_length
);
	import fqd_pkg::*;

	logic req_xfer;
	logic rsp_xfer;
	logic pend_q;
	len_t last_len_q;
	len_t len_diff;

	assign req_xfer = req_valid && req_ready;
	assign rsp_xfer = rsp_valid && rsp_ready;
	assign len_diff = rsp_length - last_len_q;

	// One request outstanding until its result transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= 1'b0;
			last_len_q <= '0;
		end else begin
			if (req_xfer) begin
				pend_q <= 1'b1;
			end else if (rsp_xfer) begin
				pend_q <= 1'b0;
			end
			if (rsp_xfer) begin
				last_len_q <= rsp_length;
			end
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_handle) && $stable(rsp_length))
		else $error("result changed while stalled");

	a_no_orphan_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q)
		else $error("result without a pending request");

	a_one_pending: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |-> !pend_q || rsp_xfer)
		else $error("request taken while a result is outstanding");

	a_len_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_xfer |-> len_diff == '0 || len_diff == len_t'(1) || len_diff == '1)
		else $error("queue length moved by more than one");

endmodule

bind fifo_queue_with_delete fqd_checker u_fqd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_handle (rsp.handle_out),
	.rsp_length (rsp.length)
);

`default_nettype wire
